/* rtl/rsi_pkg.sv */
// Shared constants, widths and types for the round screen row inset block.
package rsi_pkg;

  // Default display geometry and minimum pad
  localparam int unsigned DefScreenWidth  = 180;
  localparam int unsigned DefScreenHeight = 180;
  localparam int unsigned DefMinInset     = 6;

  // Field and datapath widths
  localparam int unsigned YW    = 10;  // signed row edge coordinate
  localparam int unsigned WW    = 9;   // row width
  localparam int unsigned PXW   = 8;   // inset, radius, half chord
  localparam int unsigned DW    = 11;  // signed distance from the vertical center
  localparam int unsigned RADW  = 16;  // radicand r*r - dy*dy
  localparam int unsigned BITW  = 15;  // one-hot root trial bit, starts at 4**7

  // floor(x/5) == (x*205) >> 10 for x < 1024; the cap uses x = 2*w
  localparam int unsigned CapMul   = 410;
  localparam int unsigned CapMulW  = 9;
  localparam int unsigned CapShift = 10;

  // Sequencer states
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIST = 6'b000010,
    S_SQR  = 6'b000100,
    S_SUB  = 6'b001000,
    S_ROOT = 6'b010000,
    S_FIN  = 6'b100000
  } rsi_state_t;

endpackage

/* rtl/round_screen_row_inset.sv */
// Round display row inset: half chord by iterative square root, capped and padded.
// Steps in order: distance, square, subtract, the 8 root steps of the square root unit
//   and its done strobe, then clamp. No new item is taken until the sequencer is back
//   in idle, so items do not overlap.
// Input stall is high while an item is in work or its result cannot be loaded.
// Reset (rst, synchronous) returns the sequencer to idle and drops output valid.
module round_screen_row_inset
  import rsi_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = DefScreenWidth,
  parameter int unsigned SCREEN_HEIGHT = DefScreenHeight,
  parameter int unsigned MIN_INSET     = DefMinInset
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [YW-1:0] row_top_y,
  input  logic signed [YW-1:0] row_bottom_y,
  input  logic [WW-1:0]        row_width,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PXW-1:0]       inset_px
);

  localparam logic [PXW-1:0]         RadPx   = PXW'(SCREEN_WIDTH / 2);
  localparam logic signed [DW-1:0]   CenterY = DW'(SCREEN_HEIGHT / 2);
  localparam logic [RADW-1:0]        RadSq   = RADW'((SCREEN_WIDTH / 2) * (SCREEN_WIDTH / 2));
  localparam logic [PXW-1:0]         MinPx   = PXW'(MIN_INSET);

  rsi_state_t state, state_next;

  logic signed [YW-1:0] top_q;
  logic signed [YW-1:0] bot_q;
  logic [WW-1:0]        width_q;
  logic [PXW-1:0]       dy;
  logic [PXW-1:0]       cap;
  logic [RADW-1:0]      dy_sq;
  logic [PXW-1:0]       half;

  logic signed [DW-1:0] dt, db;
  logic [DW-1:0]        at, ab, amax;
  logic [WW+CapMulW-1:0] cap_prod;
  logic                 sq_start;
  logic                 sq_done;
  logic [PXW-1:0]       sq_root;
  logic [RADW-1:0]      radicand;
  logic [PXW-1:0]       pad, pad_cap;
  logic                 out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Distance of the farther edge from the vertical center, clamped to the radius
  assign dt   = DW'(top_q) - CenterY;
  assign db   = DW'(bot_q) - CenterY;
  assign at   = dt[DW-1] ? DW'(-dt) : DW'(dt);
  assign ab   = db[DW-1] ? DW'(-db) : DW'(db);
  assign amax = (at > ab) ? at : ab;

  // Forty percent cap: floor(2w/5) by reciprocal multiply
  assign cap_prod = (WW+CapMulW)'(width_q) * (WW+CapMulW)'(CapMul);

  // Radicand and final clamp
  assign radicand = RadSq - dy_sq;
  assign sq_start = (state == S_SUB);
  assign pad      = RadPx - half;
  assign pad_cap  = (pad > cap) ? cap : pad;

  rsi_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (radicand),
    .done     (sq_done),
    .root     (sq_root)
  );

  // Sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_DIST;
      S_DIST: state_next = S_SQR;
      S_SQR:  state_next = S_SUB;
      S_SUB:  state_next = S_ROOT;
      S_ROOT: if (sq_done) state_next = S_FIN;
      S_FIN:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Advance the sequencer and hold the output until transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      top_q   <= row_top_y;
      bot_q   <= row_bottom_y;
      width_q <= row_width;
    end
    if (state == S_DIST) begin
      dy  <= (amax > DW'(RadPx)) ? RadPx : amax[PXW-1:0];
      cap <= cap_prod[CapShift+PXW-1:CapShift];
    end
    if (state == S_SQR) begin
      dy_sq <= RADW'(dy) * RADW'(dy);
    end
    if (state == S_ROOT && sq_done) begin
      half <= sq_root;
    end
    if (state == S_FIN && out_free) begin
      inset_px <= (pad_cap < MinPx) ? MinPx : pad_cap;
    end
  end

endmodule

/* rtl/rsi_sqrt.sv */
// Iterative floor square root of a 16-bit value, one result bit per cycle.
module rsi_sqrt
  import rsi_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [RADW-1:0] radicand,
  output logic            done,
  output logic [PXW-1:0]  root
);

  logic            busy;
  logic [RADW-1:0] rem;
  logic [RADW:0]   res;
  logic [BITW-1:0] trial;
  logic [RADW:0]   cand;
  logic            take;

  // Compare the remainder against res + trial bit
  assign cand = res + (RADW+1)'(trial);
  assign take = (RADW+1)'(rem) >= cand;
  assign root = res[PXW-1:0];

  // Control: run from start until the last trial bit is used
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && trial[0]) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: one restoring step per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= radicand;
      res   <= '0;
      trial <= BITW'(1) << (BITW-1);
    end else if (busy) begin
      if (take) begin
        rem <= RADW'((RADW+1)'(rem) - cand);
        res <= (res >> 1) + (RADW+1)'(trial);
      end else begin
        res <= res >> 1;
      end
      trial <= trial >> 2;
    end
  end

endmodule
